>>> rtl/u8d_pkg.sv
// shared widths, types and lead-byte constants of the utf-8 stream decoder
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned LenW  = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [LenW-1:0]  len_t;

  // lead-byte class masks and match patterns
  localparam byte_t MaskL1  = 8'h80;
  localparam byte_t MaskL2  = 8'he0;
  localparam byte_t MaskL3  = 8'hf0;
  localparam byte_t MaskL4  = 8'hf8;
  localparam byte_t MaskL5  = 8'hfc;
  localparam byte_t MaskL6  = 8'hfe;
  localparam byte_t MatchL2 = 8'hc0;
  localparam byte_t MatchL3 = 8'he0;
  localparam byte_t MatchL4 = 8'hf0;
  localparam byte_t MatchL5 = 8'hf8;
  localparam byte_t MatchL6 = 8'hfc;

  // payload masks of lead and continuation bytes
  localparam byte_t PayL2   = 8'h1f;
  localparam byte_t PayL3   = 8'h0f;
  localparam byte_t PayL4   = 8'h07;
  localparam byte_t PayL5   = 8'h03;
  localparam byte_t PayL6   = 8'h01;
  localparam int unsigned ContBits = 6;

  // sequence lengths
  localparam len_t LenOne = 3'd1;
  localparam len_t LenMax = 3'd6;

  // one decoded character
  typedef struct packed {
    cp_t  code_point;
    len_t seq_length;
    logic bad_lead;
  } char_t;

endpackage

`default_nettype wire

>>> rtl/u8d_if.sv
// valid/ready channel interfaces for raw bytes and decoded characters
`default_nettype none

interface u8d_byte_if;
  logic            valid;
  logic            ready;
  u8d_pkg::byte_t  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
  modport monitor (input valid, input in_byte, input ready);
endinterface

interface u8d_char_if;
  logic            valid;
  logic            ready;
  u8d_pkg::cp_t    code_point;
  u8d_pkg::len_t   seq_length;
  logic            bad_lead;

  modport source (output valid, output code_point, output seq_length, output bad_lead,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input bad_lead,
                  output ready);
  modport monitor (input valid, input code_point, input seq_length, input bad_lead,
                   input ready);
endinterface

`default_nettype wire

>>> rtl/utf8_stream_decoder_core.sv
// utf-8 stream decoder top level: input register, decode logic, result register
//
//   channel   dir   handshake     payload
//   byte_i    in    valid/ready   in_byte[7:0]
//   char_o    out   valid/ready   code_point[30:0], seq_length[2:0], bad_lead
//
// one byte per cycle sustained while the sink takes results; a result is in the result
// register once the request of its last byte is taken and has passed the input
// register and the result register, and is offered to the sink until it is taken
// a lead byte or inner continuation byte gives no result, the last byte of a
// sequence (or a one-byte character or bad lead) gives one
// rst_ni clears the open-sequence state and both valid flags
// a stalled result holds both stages; byte_i.ready stays high while the input
// register is empty or the pipeline can move
`default_nettype none

module utf8_stream_decoder_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u8d_byte_if.sink      byte_i,
  u8d_char_if.source    char_o
);

  localparam int unsigned CpW  = u8d_pkg::CpW;
  localparam int unsigned CbW  = u8d_pkg::ContBits;

  // input register
  logic           in_vld_q;
  u8d_pkg::byte_t in_byte_q;
  // open-sequence state
  u8d_pkg::len_t  left_q, left_d;
  u8d_pkg::len_t  len_q, len_d;
  u8d_pkg::cp_t   acc_q, acc_d;
  // result register
  logic           out_vld_q;
  u8d_pkg::char_t res_q, res_d;
  logic           res_new;

  logic advance;
  logic in_take;

  // pipeline moves when the result register is free or being drained
  assign advance     = !out_vld_q || char_o.ready;
  assign byte_i.ready = !in_vld_q || advance;
  assign in_take     = byte_i.valid && byte_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.in_byte;
    end
  end

  // decode of one byte against the open-sequence state
  always_comb begin
    u8d_pkg::byte_t b;
    b       = in_byte_q;
    left_d  = left_q;
    len_d   = len_q;
    acc_d   = acc_q;
    res_new = 1'b0;
    res_d   = '{code_point: '0, seq_length: u8d_pkg::LenOne, bad_lead: 1'b0};
    if (left_q != '0) begin
      // continuation byte, top bits not checked
      acc_d  = {acc_q[CpW-CbW-1:0], b[CbW-1:0]};
      left_d = left_q - 3'd1;
      if (left_q == 3'd1) begin
        res_new          = 1'b1;
        res_d.code_point = acc_d;
        res_d.seq_length = len_q;
      end
    end else begin
      priority if ((b & u8d_pkg::MaskL1) == '0) begin
        res_new          = 1'b1;
        res_d.code_point = CpW'(b);
      end else if ((b & u8d_pkg::MaskL2) == u8d_pkg::MatchL2) begin
        acc_d = CpW'(b & u8d_pkg::PayL2);
        len_d = 3'd2;
      end else if ((b & u8d_pkg::MaskL3) == u8d_pkg::MatchL3) begin
        acc_d = CpW'(b & u8d_pkg::PayL3);
        len_d = 3'd3;
      end else if ((b & u8d_pkg::MaskL4) == u8d_pkg::MatchL4) begin
        acc_d = CpW'(b & u8d_pkg::PayL4);
        len_d = 3'd4;
      end else if ((b & u8d_pkg::MaskL5) == u8d_pkg::MatchL5) begin
        acc_d = CpW'(b & u8d_pkg::PayL5);
        len_d = 3'd5;
      end else if ((b & u8d_pkg::MaskL6) == u8d_pkg::MatchL6) begin
        acc_d = CpW'(b & u8d_pkg::PayL6);
        len_d = u8d_pkg::LenMax;
      end else begin
        // invalid leader: continuation pattern or 0xfe/0xff
        res_new        = 1'b1;
        res_d.bad_lead = 1'b1;
      end
      if (!res_new) begin
        left_d = len_d - 3'd1;
      end
    end
  end

  // sequence state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      len_q     <= '0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q && res_new;
      if (in_vld_q) begin
        left_q <= left_d;
        len_q  <= len_d;
        acc_q  <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q && res_new) begin
      res_q <= res_d;
    end
  end

  assign char_o.valid      = out_vld_q;
  assign char_o.code_point = res_q.code_point;
  assign char_o.seq_length = res_q.seq_length;
  assign char_o.bad_lead   = res_q.bad_lead;

endmodule

`default_nettype wire

>>> rtl/u8d_checker.sv
// port-level checks of the utf-8 stream decoder and their binding
`default_nettype none

module u8d_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u8d_byte_if.sink    byte_i,
  u8d_char_if.source  char_o
);

  // a result waiting for the sink stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid && !char_o.ready |=> char_o.valid && $stable(char_o.code_point)
      && $stable(char_o.seq_length) && $stable(char_o.bad_lead))
    else $error("result changed while stalled");

  // a bad leader reports value zero over one byte
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid && char_o.bad_lead |->
      char_o.code_point == '0 && char_o.seq_length == u8d_pkg::LenOne)
    else $error("bad lead result malformed");

  // length always in the legal range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid |-> char_o.seq_length != 3'd0 && char_o.seq_length != 3'd7)
    else $error("sequence length out of range");

  // single-byte characters are ascii
  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid && char_o.seq_length == u8d_pkg::LenOne && !char_o.bad_lead |->
      char_o.code_point[u8d_pkg::CpW-1:7] == '0)
    else $error("one-byte character above ascii");

endmodule

bind utf8_stream_decoder_core u8d_checker u_u8d_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .byte_i (byte_i),
  .char_o (char_o)
);

`default_nettype wire

>>> tb/u8d_decode_checker.sv
`timescale 1ns / 100ps
// decoded-character checker: predicts results from taken bytes and compares them
module u8d_decode_checker
  import u8d_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  u8d_byte_if.monitor   byte_i,
  u8d_char_if.monitor   char_i,
  output int unsigned   fail_cnt_o,
  output int unsigned   pending_o,
  output int unsigned   chars_o,
  output int unsigned   bad_leads_o,
  output logic [6:0]    len_mask_o
);

  // open-sequence state of the predictor
  len_t  cont_left  = '0;
  cp_t   gathered   = '0;
  len_t  open_len   = '0;
  char_t expected_chars[$];

  initial begin
    fail_cnt_o  = 0;
    pending_o   = 0;
    chars_o     = 0;
    bad_leads_o = 0;
    len_mask_o  = '0;
  end

  // queue one expected character
  task automatic push_char(input cp_t cp, input len_t len, input logic bad);
    char_t c;
    c.code_point = cp;
    c.seq_length = len;
    c.bad_lead   = bad;
    expected_chars.push_back(c);
  endtask

  // decode one byte of the stream
  task automatic decode_byte(input byte_t b);
    len_t  lead_len;
    byte_t pay;
    lead_len = '0;
    pay      = '0;
    if (cont_left != 0) begin
      // any byte counts as continuation, low six bits only
      gathered  = {gathered[CpW-ContBits-1:0], b[ContBits-1:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == 0) push_char(gathered, open_len, 1'b0);
    end else if ((b & MaskL1) == '0) begin
      push_char(cp_t'(b), LenOne, 1'b0);
    end else begin
      if ((b & MaskL2) == MatchL2) begin
        lead_len = 3'd2; pay = b & PayL2;
      end else if ((b & MaskL3) == MatchL3) begin
        lead_len = 3'd3; pay = b & PayL3;
      end else if ((b & MaskL4) == MatchL4) begin
        lead_len = 3'd4; pay = b & PayL4;
      end else if ((b & MaskL5) == MatchL5) begin
        lead_len = 3'd5; pay = b & PayL5;
      end else if ((b & MaskL6) == MatchL6) begin
        lead_len = 3'd6; pay = b & PayL6;
      end
      if (lead_len == 0) begin
        // continuation-class byte or 0xfe/0xff where a lead belongs
        push_char('0, LenOne, 1'b1);
      end else begin
        gathered  = cp_t'(pay);
        open_len  = lead_len;
        cont_left = lead_len - 1'b1;
      end
    end
  endtask

  // compare one taken character with the oldest expectation
  task automatic check_char();
    char_t exp_c;
    if (expected_chars.size() == 0) begin
      $error("unexpected character: code_point %h seq_length %0d bad_lead %b",
             char_i.code_point, char_i.seq_length, char_i.bad_lead);
      fail_cnt_o++;
    end else begin
      exp_c = expected_chars.pop_front();
      if (char_i.code_point !== exp_c.code_point) begin
        $error("code_point: expected %h, actual %h", exp_c.code_point, char_i.code_point);
        fail_cnt_o++;
      end
      if (char_i.seq_length !== exp_c.seq_length) begin
        $error("seq_length: expected %0d, actual %0d", exp_c.seq_length, char_i.seq_length);
        fail_cnt_o++;
      end
      if (char_i.bad_lead !== exp_c.bad_lead) begin
        $error("bad_lead: expected %b, actual %b", exp_c.bad_lead, char_i.bad_lead);
        fail_cnt_o++;
      end
      chars_o++;
      if (exp_c.bad_lead) bad_leads_o++;
      if (exp_c.seq_length >= 1 && exp_c.seq_length <= 6)
        len_mask_o[exp_c.seq_length-1] = 1'b1;
    end
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_left = '0;
      gathered  = '0;
      open_len  = '0;
    end else begin
      if (byte_i.valid && byte_i.ready) decode_byte(byte_i.in_byte);
      if (char_i.valid && char_i.ready) check_char();
      pending_o = expected_chars.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, byte stimulus, result back-pressure and verdict
module tb;
  import u8d_pkg::*;

  localparam int unsigned RandBytes   = 550;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned HoldBytes   = 24;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  u8d_byte_if byte_if ();
  u8d_char_if char_if ();

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned chars_seen;
  int unsigned bad_seen;
  logic [6:0]  len_mask;

  int unsigned sent_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned src_idle    = 0;
  int unsigned snk_idle    = 0;
  logic        hold_req    = 1'b0;
  logic        hold_taken  = 1'b0;
  int unsigned hold_left   = 0;

  utf8_stream_decoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_if.sink),
    .char_o (char_if.source)
  );

  u8d_decode_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .byte_i      (byte_if.monitor),
    .char_i      (char_if.monitor),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .chars_o     (chars_seen),
    .bad_leads_o (bad_seen),
    .len_mask_o  (len_mask)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("utf8_stream_decoder_core regression: fail");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      char_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left     <= HoldCycles - 1;
      hold_taken    <= 1'b1;
      char_if.ready <= 1'b0;
    end else begin
      char_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // offer one byte and wait for its request to be taken
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    logic        taken;
    gap = 0;
    while ($urandom_range(99) < src_idle) gap++;
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    do begin
      @(negedge clk);
      taken = byte_if.ready;
      @(posedge clk);
    end while (!taken);
    sent_cnt++;
  endtask

  // one well-formed character of random length and content
  task automatic send_char();
    int unsigned len;
    byte_t       r;
    byte_t       lead;
    len  = $urandom_range(1, 6);
    r    = byte_t'($urandom);
    case (len)
      1:       lead = r & ~MaskL1;
      2:       lead = MatchL2 | (r & PayL2);
      3:       lead = MatchL3 | (r & PayL3);
      4:       lead = MatchL4 | (r & PayL4);
      5:       lead = MatchL5 | (r & PayL5);
      default: lead = MatchL6 | (r & PayL6);
    endcase
    send_byte(lead);
    for (int i = 1; i < len; i++) send_byte(MaskL1 | (byte_t'($urandom) & 8'h3f));
  endtask

  // mix of well-formed characters, bad leads and raw noise
  task automatic send_random(input int unsigned upto);
    int unsigned pick;
    while (sent_cnt < upto) begin
      pick = $urandom_range(99);
      if (pick < 75) send_char();
      else if (pick < 85) begin
        if ($urandom_range(3) == 0) send_byte(MaskL6 | byte_t'($urandom_range(1)));
        else send_byte(byte_t'($urandom_range(8'h80, 8'hbf)));
      end else send_byte(byte_t'($urandom));
    end
  endtask

  // directed stream: ascii ends, bad leads, longest forms, malformed continuations
  byte_t directed_bytes[] = '{
    8'h00, 8'h7f, 8'h80, 8'hbf, 8'hfe, 8'hff,
    8'hc0, 8'h80,
    8'hef, 8'hbf, 8'hbf,
    8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
    8'hc3, 8'h41,
    8'he1, 8'hfe, 8'h00,
    8'hf4, 8'h8f, 8'hbf, 8'hbf
  };

  initial begin
    int unsigned base;
    byte_if.valid   = 1'b0;
    byte_if.in_byte = '0;
    char_if.ready   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sender sparse gaps, receiver heavy stalls
    src_idle = 11;
    snk_idle = 53;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // long receiver hold-off while bytes keep coming
    hold_req <= 1'b1;
    base = sent_cnt;
    while (sent_cnt < base + HoldBytes) send_char();

    base = sent_cnt;
    send_random(base + RandBytes / 3);
    // sender heavy gaps, receiver sparse stalls
    src_idle = 53;
    snk_idle = 11;
    send_random(base + 2 * RandBytes / 3);
    // full rate both sides
    src_idle = 0;
    snk_idle = 0;
    send_random(base + RandBytes);
    byte_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d bytes, checked %0d characters of which %0d had a bad lead",
             sent_cnt, chars_seen, bad_seen);
    $display("sequence lengths seen (bit n = length n+1): %b", len_mask);
    if (fail_cnt == 0) begin
      $display("utf8_stream_decoder_core regression: pass");
    end else begin
      $display("utf8_stream_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

>>> utf8_stream_decoder_core.f
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/utf8_stream_decoder_core.sv
rtl/u8d_checker.sv
tb/u8d_decode_checker.sv
tb/tb.sv
